>>> sv/rtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and codes for the retransmit timer table
// Opcodes, result kinds and the entry record held by each cell.
// ----------------------------------------------------------------------------
package rtt_pkg;

   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_ACK    = 3'd1;
   localparam logic [2:0] OP_TICK   = 3'd2;
   localparam logic [2:0] OP_PAUSE  = 3'd3;
   localparam logic [2:0] OP_RESUME = 3'd4;
   localparam logic [2:0] OP_FAIL   = 3'd5;

   localparam logic [2:0] KIND_ADDED     = 3'd0;
   localparam logic [2:0] KIND_FULL      = 3'd1;
   localparam logic [2:0] KIND_ACKED     = 3'd2;
   localparam logic [2:0] KIND_UNMATCHED = 3'd3;
   localparam logic [2:0] KIND_RETX      = 3'd4;
   localparam logic [2:0] KIND_GAVE_UP   = 3'd5;
   localparam logic [2:0] KIND_FAILED    = 3'd6;
   localparam logic [2:0] KIND_DONE      = 3'd7;

   // Entry contents, handed from cell to cell around the ring.
   typedef struct packed {
      logic        live;
      logic        mark;    // entry owes a result in the send pass
      logic [7:0]  exch;
      logic [31:0] msg;
      logic [7:0]  sends;
      logic [15:0] count;
      logic [15:0] reload;
   } entry_type;

endpackage
`default_nettype wire

>>> sv/rtt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_cell: one table entry in the rotating ring
// Holds an entry; on rotate takes the neighbor's, at the head takes new data.
// ----------------------------------------------------------------------------
module rtt_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  rotate,
   input  rtt_pkg::entry_type   prev_entry,
   output rtt_pkg::entry_type   entry
);
   import rtt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (rotate) begin
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         entry_ff.live <= 1'b0;
      end
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

>>> sv/rtt_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_divider: radix-2 restoring divider
// Divides a 32-bit dividend by a 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtt_divider (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire [31:0]  dividend,
   input  wire [15:0]  divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import rtt_pkg::*;

   logic [31:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[15:0], quot_ff[31]};
      if (start) begin
         quot_in = dividend;
         rem_in  = 17'd0;
         dvs_in  = (divisor == 16'd0) ? 16'd1 : divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      busy_ff <= busy_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end
   end

   assign done     = busy_ff && (cnt_ff == 6'd1);
   assign quotient = quot_in;

endmodule
`default_nettype wire

>>> sv/retransmit_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// retransmit_timer_table: table of unacknowledged messages with timers
// Add, ack, tick, pause, resume and fail-exchange over a ring of entry cells.
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_SIZE cells that, during a pass, rotates one
// place a cycle past a single head position, where the sequencer inspects
// and rewrites the entry; the send pass holds the ring while a result waits
// on rsp_tready. Every item takes two full rotations: the first locates the
// free or matching slot (tick subtracts the elapsed ticks there), the second
// applies the change, marks entries that owe a result and gathers the
// earliest wake time. Tick and fail exchange then take a third rotation that
// sends one result per marked entry, and every item ends with its final
// result. Add and pause first run through the serial divider. A result that
// waits on rsp_tready holds the item back. No clearing pass after reset.
// ----------------------------------------------------------------------------
module retransmit_timer_table #(
   parameter int TABLE_SIZE = 16
) (
   input  wire         clock,
   input  wire         reset,
   // req_tuser: opcode[2:0]
   // req_tdata: exchange_id[7:0], msg_ident[39:8], timeout_ms[63:40],
   //            pause_ms[95:64], elapsed_ticks[111:96]
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [111:0] req_tdata,
   input  wire [2:0]   req_tuser,
   // rsp_tuser: kind[2:0]
   // rsp_tdata: slot[3:0], out_exchange[11:4], out_message[43:12],
   //            send_total[51:44], wake_valid[52], next_wake[68:53]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire [2:0]   csr_paddr,
   input  wire [31:0]  csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rtt_pkg::*;

   localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int CNT_W = $clog2(TABLE_SIZE + 1);
   localparam logic [2:0] ADDR_RETRIES  = 3'd0;
   localparam logic [2:0] ADDR_INTERVAL = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_PASS1, ST_PASS2, ST_FINAL, ST_EMIT
   } state_type;

   // ---------------- configuration ----------------
   logic [7:0]  retries_ff;
   logic [15:0] interval_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         retries_ff  <= 8'd3;
         interval_ff <= 16'd200;
      end else if (csr_wr) begin
         if (csr_paddr == ADDR_RETRIES) begin
            retries_ff <= csr_pwdata[7:0];
         end else if (csr_paddr == ADDR_INTERVAL) begin
            interval_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr == ADDR_RETRIES) begin
         csr_prdata = {24'd0, retries_ff};
      end else if (csr_paddr == ADDR_INTERVAL) begin
         csr_prdata = {16'd0, interval_ff};
      end
   end

   // ---------------- ring of cells ----------------
   entry_type   cell_q [TABLE_SIZE];
   entry_type   head_new;
   logic        rotate;

   for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
      if (g == 0) begin : g_head
         rtt_cell u_cell (
            .clock(clock), .reset(reset), .rotate(rotate),
            .prev_entry(head_new), .entry(cell_q[g])
         );
      end else begin : g_rest
         rtt_cell u_cell (
            .clock(clock), .reset(reset), .rotate(rotate),
            .prev_entry(cell_q[g-1]), .entry(cell_q[g])
         );
      end
   end

   // head of the ring is the last cell; it re-enters at cell 0
   entry_type head;
   assign head = cell_q[TABLE_SIZE-1];

   // ---------------- divider ----------------
   logic        div_start, div_done;
   logic [31:0] div_q, div_arg;

   rtt_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_arg), .divisor(interval_ff),
      .done(div_done), .quotient(div_q)
   );

   // ---------------- sequencer ----------------
   state_type   state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [7:0]  exch_ff, exch_in;
   logic [31:0] msg_ff, msg_in;
   logic [15:0] ela_ff, ela_in;
   logic [15:0] quo_ff, quo_in;
   logic [IDX_W-1:0] pos_ff, pos_in;    // slot at head
   logic [CNT_W-1:0] step_ff, step_in;
   logic        found_ff, found_in;
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic        any_ff, any_in;
   logic [15:0] wake_ff, wake_in;
   logic        rv_ff, rv_in;
   logic [2:0]  rkind_ff, rkind_in;
   logic [3:0]  rslot_ff, rslot_in;
   logic [7:0]  rexch_ff, rexch_in;
   logic [31:0] rmsg_ff, rmsg_in;
   logic [7:0]  rsend_ff, rsend_in;
   logic        rlast_ff, rlast_in;

   logic [2:0]  q_op;
   logic [7:0]  q_exch;
   logic [31:0] q_msg;
   logic [23:0] q_tmo;
   logic [31:0] q_pms;
   logic [15:0] q_ela;

   assign q_op   = req_tuser;
   assign q_exch = req_tdata[7:0];
   assign q_msg  = req_tdata[39:8];
   assign q_tmo  = req_tdata[63:40];
   assign q_pms  = req_tdata[95:64];
   assign q_ela  = req_tdata[111:96];

   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign div_start = req_tvalid && req_tready &&
                      (q_op == OP_ADD || q_op == OP_PAUSE);
   assign div_arg = (q_op == OP_ADD) ? {8'd0, q_tmo} : q_pms;

   // Per-entry results of tick and fail need the final wake time, so pass 2
   // only marks the entries and a third rotation sends them in slot order.
   entry_type   cur;
   logic        match_x, match_m;
   logic [15:0] sub;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; exch_in = exch_ff; msg_in = msg_ff;
      ela_in = ela_ff; quo_in = quo_ff; pos_in = pos_ff; step_in = step_ff;
      found_in = found_ff; hit_in = hit_ff; any_in = any_ff; wake_in = wake_ff;
      rv_in = rv_ff; rkind_in = rkind_ff; rslot_in = rslot_ff;
      rexch_in = rexch_ff; rmsg_in = rmsg_ff; rsend_in = rsend_ff;
      rlast_in = rlast_ff;
      rotate = 1'b0;
      head_new = head;
      cur = head;
      match_x = head.live && (head.exch == exch_ff);
      match_m = match_x && (head.msg == msg_ff);
      sub = (head.count >= ela_ff) ? head.count - ela_ff : 16'd0;

      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = q_op; exch_in = q_exch; msg_in = q_msg;
               ela_in = q_ela;
               found_in = 1'b0; hit_in = '0;
               pos_in = '0; step_in = '0;
               any_in = 1'b0; wake_in = 16'hFFFF;
               state_in = div_start ? ST_DIV : ST_PASS1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               quo_in = div_q[15:0];
               state_in = ST_PASS1;
            end
         end
         ST_PASS1: begin
            // locate first free / matching slot; tick subtracts here
            rotate = 1'b1;
            if (op_ff == OP_ADD && !found_ff && !head.live) begin
               found_in = 1'b1; hit_in = pos_ff;
            end
            if (op_ff == OP_ACK && !found_ff && match_m) begin
               found_in = 1'b1; hit_in = pos_ff;
            end
            if ((op_ff == OP_PAUSE || op_ff == OP_RESUME) && !found_ff && match_x) begin
               found_in = 1'b1; hit_in = pos_ff;
            end
            if (op_ff == OP_TICK && head.live) begin
               head_new.count = sub;
            end
            pos_in = pos_ff + IDX_W'(1);
            step_in = step_ff + CNT_W'(1);
            if (step_ff == CNT_W'(TABLE_SIZE - 1)) begin
               pos_in = '0; step_in = '0;
               state_in = ST_PASS2;
            end
         end
         ST_PASS2: begin
            // apply change, mark entries owing a result, gather wake time
            rotate = 1'b1;
            cur = head;
            cur.mark = 1'b0;
            case (op_ff)
               OP_ADD: begin
                  if (found_ff && hit_ff == pos_ff) begin
                     cur.live = 1'b1; cur.exch = exch_ff; cur.msg = msg_ff;
                     cur.sends = 8'd0; cur.count = quo_ff; cur.reload = quo_ff;
                  end
               end
               OP_ACK: begin
                  if (found_ff && hit_ff == pos_ff) begin
                     cur.live = 1'b0;
                     rsend_in = head.sends;
                  end
               end
               OP_TICK: begin
                  if (head.live && head.count == 16'd0) begin
                     cur.mark = 1'b1;
                     if (head.sends > retries_ff) begin
                        cur.live = 1'b0;
                     end else begin
                        cur.sends = head.sends + 8'd1;
                        cur.count = head.reload;
                     end
                  end
               end
               OP_PAUSE: begin
                  if (found_ff && hit_ff == pos_ff) begin
                     cur.count = head.count + quo_ff;
                  end
               end
               OP_RESUME: begin
                  if (found_ff && hit_ff == pos_ff) begin
                     cur.count = 16'd0;
                  end
               end
               OP_FAIL: begin
                  if (match_x) begin
                     cur.live = 1'b0;
                     cur.mark = 1'b1;
                  end
               end
               default: ;
            endcase
            head_new = cur;
            if (cur.live) begin
               any_in = 1'b1;
               if (cur.count < wake_ff) wake_in = cur.count;
            end
            pos_in = pos_ff + IDX_W'(1);
            step_in = step_ff + CNT_W'(1);
            if (step_ff == CNT_W'(TABLE_SIZE - 1)) begin
               pos_in = '0; step_in = '0;
               state_in = (op_ff == OP_TICK || op_ff == OP_FAIL) ? ST_EMIT : ST_FINAL;
            end
         end
         ST_EMIT: begin
            // walk the ring again, send one result per marked slot
            if (!head.mark) begin
               rotate = 1'b1;
            end else if (!rv_ff || rsp_tready) begin
               rotate = 1'b1;
               rv_in = 1'b1;
               if (op_ff == OP_FAIL) begin
                  rkind_in = KIND_FAILED;
               end else if (head.live) begin
                  rkind_in = KIND_RETX;
               end else begin
                  rkind_in = KIND_GAVE_UP;
               end
               rslot_in = 4'(pos_ff); rexch_in = head.exch; rmsg_in = head.msg;
               rsend_in = head.sends; rlast_in = 1'b0;
            end
            if (rotate) begin
               pos_in = pos_ff + IDX_W'(1);
               step_in = step_ff + CNT_W'(1);
               if (step_ff == CNT_W'(TABLE_SIZE - 1)) begin
                  pos_in = '0; step_in = '0;
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1; rlast_in = 1'b1;
               rexch_in = exch_ff; rslot_in = 4'd0; rmsg_in = 32'd0;
               rsend_in = 8'd0; rkind_in = KIND_DONE;
               case (op_ff)
                  OP_ADD: begin
                     rmsg_in = msg_ff;
                     if (found_ff) begin
                        rkind_in = KIND_ADDED; rslot_in = 4'(hit_ff);
                     end else begin
                        rkind_in = KIND_FULL;
                     end
                  end
                  OP_ACK: begin
                     rmsg_in = msg_ff;
                     if (found_ff) begin
                        rkind_in = KIND_ACKED; rslot_in = 4'(hit_ff);
                        rsend_in = rsend_ff;
                     end else begin
                        rkind_in = KIND_UNMATCHED;
                     end
                  end
                  default: ;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      op_ff <= op_in; exch_ff <= exch_in; msg_ff <= msg_in;
      ela_ff <= ela_in; quo_ff <= quo_in; pos_ff <= pos_in; step_ff <= step_in;
      found_ff <= found_in; hit_ff <= hit_in; any_ff <= any_in;
      wake_ff <= wake_in; rv_ff <= rv_in; rkind_ff <= rkind_in;
      rslot_ff <= rslot_in; rexch_ff <= rexch_in; rmsg_ff <= rmsg_in;
      rsend_ff <= rsend_in; rlast_ff <= rlast_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end
   end

   logic [15:0] wake_out;
   assign wake_out = any_ff ? wake_ff : 16'd0;
   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tuser  = rkind_ff;
   assign rsp_tdata  = {3'd0, wake_out, any_ff, rsend_ff, rmsg_ff, rexch_ff,
                        rslot_ff};

   // ---------------- assertions ----------------
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("item accepted while busy");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rkind_ff == KIND_DONE) |-> rlast_ff)
      else $error("done result without last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_tready) |=> (rv_ff && $stable(rkind_ff) && $stable(rslot_ff)))
      else $error("stalled result changed");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rlast_ff && rsp_tready) |-> (state_ff == ST_IDLE))
      else $error("last result left before item finished");

endmodule
`default_nettype wire
